[sv/sha256_stream_hasher_unit_assert.svh]
// Assertion macros for the hasher
`ifndef SHA256_STREAM_HASHER_UNIT_ASSERT_SVH
`define SHA256_STREAM_HASHER_UNIT_ASSERT_SVH
// implication, checked on every edge outside reset
`define SHA_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sha256 check failed");
// implication to the next cycle
`define SHA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sha256 check failed");
`endif

[sv/sha_pkg.sv]
// ----------------------------------------------------------------------------
// sha_pkg
// Shared types, constants and functions of the SHA-256 hasher.
// ----------------------------------------------------------------------------
package sha_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MARK,
        ST_PAD,
        ST_ROUND,
        ST_ADD,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic       wr_byte;    // shift in_byte into the block, count length
        logic       wr_pad;     // shift pad byte into the block
        logic [1:0] pad_sel;    // 0: zero, 1: 0x80, 2: length byte
        logic       init_vars;
        logic       round;
        logic       add_chain;
        logic       restart;
        logic       out_inc;
    } cmd_t;

    typedef struct packed {
        logic       full;       // fill pointer is 63
        logic [5:0] ptr;
        logic [5:0] round_cnt;
        logic [2:0] out_idx;
    } status_t;

    localparam logic [1:0] PAD_ZERO = 2'd0;
    localparam logic [1:0] PAD_MARK = 2'd1;
    localparam logic [1:0] PAD_LEN  = 2'd2;

    localparam logic [255:0] H_INIT = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    function automatic logic [31:0] round_k(input logic [5:0] t);
        logic [31:0] k;
        unique case (t)
            6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491;
            6'd2: k = 32'hb5c0fbcf; 6'd3: k = 32'he9b5dba5;
            6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5;
            6'd8: k = 32'hd807aa98; 6'd9: k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

endpackage

[sv/sha_datapath.sv]
// ----------------------------------------------------------------------------
// sha_datapath
// Block buffer, message schedule, round unit and chaining value.
// ----------------------------------------------------------------------------
module sha_datapath
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [7:0]       in_byte,
    input  sha_pkg::cmd_t    cmd,
    output sha_pkg::status_t status,
    output logic [31:0]      digest_out
);
    import sha_pkg::*;

    logic [5:0]   ptr_reg;
    logic [5:0]   rnd_reg;
    logic [2:0]   out_reg;
    logic [63:0]  bits_reg;
    logic [255:0] h_reg;
    logic [31:0]  v_reg [0:7];
    logic [31:0]  w_reg [0:15];
    logic [7:0]   pad_byte;
    logic [7:0]   sh_byte;
    logic [63:0]  len_sh;
    logic [31:0]  w_new, w_cur, t1, t2, s0, s1, e0, e1, x2, x15;

    // length bytes go out most significant first at pointer 56..63
    assign len_sh = bits_reg >> {~ptr_reg[2:0], 3'b000};
    always_comb
    begin
        case (cmd.pad_sel)
            PAD_MARK: pad_byte = 8'h80;
            PAD_LEN:  pad_byte = len_sh[7:0];
            default:  pad_byte = 8'h00;
        endcase
    end
    assign sh_byte = cmd.wr_byte ? in_byte : pad_byte;

    assign x2  = w_reg[14];
    assign x15 = w_reg[1];
    assign s1 = {x2[16:0], x2[31:17]} ^ {x2[18:0], x2[31:19]} ^ (x2 >> 10);
    assign s0 = {x15[6:0], x15[31:7]} ^ {x15[17:0], x15[31:18]} ^ (x15 >> 3);
    assign w_new = s1 + w_reg[9] + s0 + w_reg[0];
    assign w_cur = (rnd_reg < 6'd16) ? w_reg[rnd_reg[3:0]] : w_new;

    assign e1 = {v_reg[4][5:0], v_reg[4][31:6]} ^ {v_reg[4][10:0], v_reg[4][31:11]}
              ^ {v_reg[4][24:0], v_reg[4][31:25]};
    assign e0 = {v_reg[0][1:0], v_reg[0][31:2]} ^ {v_reg[0][12:0], v_reg[0][31:13]}
              ^ {v_reg[0][21:0], v_reg[0][31:22]};
    assign t1 = v_reg[7] + e1 + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
              + round_k(rnd_reg) + w_cur;
    assign t2 = e0 + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2])
              ^ (v_reg[1] & v_reg[2]));

    // block bytes shift through the schedule window, first byte ends in word 0
    always_ff @(posedge clk)
    begin
        if (cmd.wr_byte || cmd.wr_pad)
        begin
            for (int i = 0; i < 15; i++)
                w_reg[i] <= {w_reg[i][23:0], w_reg[i + 1][31:24]};
            w_reg[15] <= {w_reg[15][23:0], sh_byte};
        end
        else if (cmd.round && rnd_reg >= 6'd16)
        begin
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i + 1];
            w_reg[15] <= w_new;
        end
        if (cmd.init_vars)
            for (int i = 0; i < 8; i++)
                v_reg[i] <= h_reg[255 - 32 * i -: 32];
        else if (cmd.round)
        begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg  <= '0;
            rnd_reg  <= '0;
            out_reg  <= '0;
            bits_reg <= '0;
            h_reg    <= H_INIT;
        end
        else
        begin
            if (cmd.wr_byte || cmd.wr_pad)
                ptr_reg <= ptr_reg + 6'd1;
            if (cmd.wr_byte)
                bits_reg <= bits_reg + 64'd8;
            if (cmd.init_vars)
                rnd_reg <= '0;
            else if (cmd.round)
                rnd_reg <= rnd_reg + 6'd1;
            if (cmd.add_chain)
                for (int i = 0; i < 8; i++)
                    h_reg[255 - 32 * i -: 32] <= h_reg[255 - 32 * i -: 32] + v_reg[i];
            if (cmd.out_inc)
                out_reg <= out_reg + 3'd1;
            if (cmd.restart)
            begin
                h_reg    <= H_INIT;
                bits_reg <= '0;
                ptr_reg  <= '0;
                out_reg  <= '0;
            end
        end
    end

    assign status.full      = (ptr_reg == 6'd63);
    assign status.ptr       = ptr_reg;
    assign status.round_cnt = rnd_reg;
    assign status.out_idx   = out_reg;
    assign digest_out = h_reg[{~out_reg, 5'b00000} +: 32];
endmodule

[sv/sha_ctrl.sv]
// ----------------------------------------------------------------------------
// sha_ctrl
// Sequencer: byte intake, padding, rounds and digest output.
// ----------------------------------------------------------------------------
module sha_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_byte_valid,
    input  logic             in_end,
    input  logic             out_stall,
    input  sha_pkg::status_t status,
    output sha_pkg::cmd_t    cmd,
    output logic             in_stall,
    output logic             out_valid
);
    import sha_pkg::*;

    state_t state_reg, state_next;
    logic   fin_reg, fin_next;   // end pending: pad after current block
    logic   pad_reg, pad_next;   // 0x80 mark already written
    logic   lenb_reg, lenb_next; // current block carries the length

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fin_reg   <= 1'b0;
            pad_reg   <= 1'b0;
            lenb_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fin_reg   <= fin_next;
            pad_reg   <= pad_next;
            lenb_reg  <= lenb_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        fin_next   = fin_reg;
        pad_next   = pad_reg;
        lenb_next  = lenb_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        out_valid  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.wr_byte = in_byte_valid;
                    fin_next    = in_end;
                    if (in_byte_valid && status.full)
                    begin
                        cmd.init_vars = 1'b1;
                        state_next    = ST_ROUND;
                    end
                    else if (in_end)
                        state_next = ST_MARK;
                end
            end
            ST_MARK:
            begin
                cmd.wr_pad  = 1'b1;
                cmd.pad_sel = PAD_MARK;
                pad_next    = 1'b1;
                lenb_next   = (status.ptr < 6'd56);
                if (status.full)
                begin
                    cmd.init_vars = 1'b1;
                    state_next    = ST_ROUND;
                end
                else
                    state_next = ST_PAD;
            end
            ST_PAD:
            begin
                cmd.wr_pad  = 1'b1;
                cmd.pad_sel = (lenb_reg && status.ptr >= 6'd56) ? PAD_LEN : PAD_ZERO;
                if (status.full)
                begin
                    cmd.init_vars = 1'b1;
                    state_next    = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                cmd.round = 1'b1;
                if (status.round_cnt == 6'd63)
                    state_next = ST_ADD;
            end
            ST_ADD:
            begin
                cmd.add_chain = 1'b1;
                if (!fin_reg)
                    state_next = ST_IDLE;
                else if (lenb_reg)
                    state_next = ST_OUT;
                else if (pad_reg)
                begin
                    // length goes into a fresh block
                    lenb_next  = 1'b1;
                    state_next = ST_PAD;
                end
                else
                    state_next = ST_MARK;
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                begin
                    cmd.out_inc = 1'b1;
                    if (status.out_idx == 3'd7)
                    begin
                        cmd.restart = 1'b1;
                        fin_next    = 1'b0;
                        pad_next    = 1'b0;
                        lenb_next   = 1'b0;
                        state_next  = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end
endmodule

[sv/sha256_stream_hasher_unit.sv]
// ----------------------------------------------------------------------------
// sha256_stream_hasher_unit
// SHA-256 over a byte stream; eight digest words per message.
//
//   channel   valid      stall      words
//   in        in_valid   in_stall   data_byte, byte_valid, end_of_message
//   out       out_valid  out_stall  digest_word, word_index, last_word
//
// A byte word is taken while idle; the byte that fills a block starts the
// rounds and the chaining add, with in_stall high.
// An end word adds the 0x80 mark, pad and length bytes, rounds and add;
// with 56 or more bytes pending the length moves to a further block.
// Then the eight digest words go out, held while out_stall is high.
// Reset restores the initial hash value and clears the length and pointer.
// ----------------------------------------------------------------------------
module sha256_stream_hasher_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        byte_valid,
    input  logic        end_of_message,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);
    import sha_pkg::*;
`include "sha256_stream_hasher_unit_assert.svh"

    cmd_t    cmd;
    status_t status;

    sha_ctrl u_ctrl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_byte_valid (byte_valid),
        .in_end        (end_of_message),
        .out_stall     (out_stall),
        .status        (status),
        .cmd           (cmd),
        .in_stall      (in_stall),
        .out_valid     (out_valid)
    );

    sha_datapath u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_byte    (data_byte),
        .cmd        (cmd),
        .status     (status),
        .digest_out (digest_word)
    );

    assign word_index = status.out_idx;
    assign last_word  = (status.out_idx == 3'd7);

    `SHA_ASSERT_IMP(a_no_both, out_valid, in_stall)
    `SHA_ASSERT_IMP(a_round_excl, cmd.round, !cmd.wr_pad && !cmd.wr_byte)
    `SHA_ASSERT_NEXT(a_last_wrap, out_valid && !out_stall && last_word, word_index == 3'd0)
endmodule

[tb/sha256_stream_hasher_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_stream_hasher_unit_tb
// Drives byte streams and end marks into the hasher through the valid/stall
// handshake, predicts the SHA-256 digest of each message and checks every
// digest word against it, with random idling on both sides.
// ----------------------------------------------------------------------------
class digest_scoreboard;
    logic [31:0] hash_state [8];
    logic [7:0]  msg_block [64];
    int unsigned block_fill;
    logic [63:0] bit_count;
    logic [31:0] pending_digest [$];
    logic [2:0]  pending_index [$];
    logic        pending_last [$];
    int unsigned fail_count;

    function new();
        fail_count = 0;
        restart();
    endfunction

    function void restart();
        hash_state = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
                       32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
        block_fill = 0;
        bit_count = '0;
    endfunction

    function logic [31:0] rotr(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function void compress();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1, t2;
        for (int t = 0; t < 16; t++)
            w[t] = {msg_block[4*t], msg_block[4*t+1], msg_block[4*t+2], msg_block[4*t+3]};
        for (int t = 16; t < 64; t++)
            w[t] = (rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10)) + w[t-7]
                 + (rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3)) + w[t-16];
        v = hash_state;
        for (int t = 0; t < 64; t++)
        begin
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha_pkg::round_k(t[5:0]) + w[t];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            hash_state[i] += v[i];
    endfunction

    function void note_word(logic [7:0] data, logic has_byte, logic eom);
        int unsigned i;
        if (has_byte)
        begin
            msg_block[block_fill] = data;
            block_fill++;
            bit_count += 8;
            if (block_fill == 64)
            begin
                compress();
                block_fill = 0;
            end
        end
        if (!eom)
            return;
        i = block_fill;
        msg_block[i++] = 8'h80;
        if (i > 56)
        begin
            while (i < 64) msg_block[i++] = 8'h00;
            compress();
            i = 0;
        end
        while (i < 56) msg_block[i++] = 8'h00;
        for (int k = 0; k < 8; k++)
            msg_block[56+k] = bit_count[63-8*k -: 8];
        compress();
        for (int k = 0; k < 8; k++)
        begin
            pending_digest.push_back(hash_state[k]);
            pending_index.push_back(k[2:0]);
            pending_last.push_back(k == 7);
        end
        restart();
    endfunction

    function void check_word(logic [31:0] dw, logic [2:0] idx, logic lw);
        logic [31:0] e_dw;
        logic [2:0]  e_idx;
        logic        e_lw;
        if (pending_digest.size() == 0)
        begin
            $error("unexpected digest word %h", dw);
            fail_count++;
            return;
        end
        e_dw = pending_digest.pop_front();
        e_idx = pending_index.pop_front();
        e_lw = pending_last.pop_front();
        if (dw !== e_dw)
        begin
            $error("digest_word expected %h actual %h", e_dw, dw);
            fail_count++;
        end
        if (idx !== e_idx)
        begin
            $error("word_index expected %0d actual %0d", e_idx, idx);
            fail_count++;
        end
        if (lw !== e_lw)
        begin
            $error("last_word expected %0d actual %0d", e_lw, lw);
            fail_count++;
        end
    endfunction
endclass

module sha256_stream_hasher_unit_tb;
    localparam int IDLE_LIMIT = 20000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte = '0;
    logic        byte_valid = 1'b0;
    logic        end_of_message = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned quiet_cycles;
    digest_scoreboard sb;

    sha256_stream_hasher_unit uut (.*);

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_word(data_byte, byte_valid, end_of_message);
            if (out_valid && !out_stall)
                sb.check_word(digest_word, word_index, last_word);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= IDLE_LIMIT)
            begin
                $display("[sha256_stream_hasher_unit] ERROR");
                $finish;
            end
        end
    end

    always @(negedge clk)
        out_stall <= ($urandom_range(99) < recv_idle_pct);

    // leaves in_valid high at the falling edge after acceptance; the next
    // word or drain() takes it over at that edge
    task automatic send_word(logic [7:0] d, logic bv, logic eom);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= d;
        byte_valid <= bv;
        end_of_message <= eom;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_message(int unsigned len, bit tail_byte);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(9) == 0)
                send_word(8'($urandom), 1'b0, 1'b0);
            send_word(8'($urandom), 1'b1, 1'b0);
        end
        send_word(8'($urandom), tail_byte, 1'b1);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending_digest.size() != 0) @(negedge clk);
        repeat (300) @(negedge clk);
    endtask

    initial
    begin
        sb = new();
        send_idle_pct = 34;
        recv_idle_pct = 61;
        quiet_cycles = 0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // empty message, extremes, block edges
        send_word(8'h00, 1'b0, 1'b1);
        send_word(8'hff, 1'b0, 1'b0);
        send_word(8'h00, 1'b1, 1'b0);
        send_word(8'hff, 1'b1, 1'b1);
        send_word(8'h61, 1'b1, 1'b1);
        drain();
        send_message(55, 1'b1);
        send_message(63, 1'b1);
        drain();

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 34 : (phase == 1) ? 61 : 0;
            recv_idle_pct = (phase == 0) ? 61 : (phase == 1) ? 34 : 0;
            for (int m = 0; m < 2; m++)
                send_message($urandom_range(0, 12), 1'($urandom_range(1)));
            drain();
        end

        while (sb.pending_digest.size() != 0) @(negedge clk);
        repeat (300) @(negedge clk);
        if (sb.fail_count == 0 && sb.pending_digest.size() == 0)
            $display("[sha256_stream_hasher_unit] OK");
        else
            $display("[sha256_stream_hasher_unit] ERROR");
        $finish;
    end
endmodule
